// File: rtl/core/assert_macros.svh
// Assertion macros shared by the console writer RTL.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property holds at every clock edge outside reset.
`define TCW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("console writer assertion failed");

// Whenever a holds, b holds at the next clock edge.
`define TCW_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("console writer assertion failed");

`else

`define TCW_ASSERT(label, clk, rst, prop)
`define TCW_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// File: rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies; tcw_ctrl, tcw_outbuf and text_console_writer_core import this package.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CELL_W     = 16;
  localparam int COLOR_W    = 4;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_FG     = 4'h7;
  localparam logic [COLOR_W-1:0] RESET_BG     = 4'h0;
  localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_BG, RESET_FG, BLANK_CHAR};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } cmd_word_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row_now;
    logic [COL_W-1:0]  cursor_col_now;
    logic              scrolled;
  } rsp_word_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FILL
  } state_t;

endpackage

// File: rtl/core/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tcw_ctrl.sv
// Command sequencer: cursor, colors and all accesses to the screen RAM.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  localparam int CELLS  = ROWS * COLUMNS,
  localparam int AW     = $clog2(CELLS)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  tcw_pkg::cmd_word_t               cmd,
  input  logic                             cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             buf_full,
  output logic                             res_valid,
  output tcw_pkg::rsp_word_t               res,
  output logic                             ram_we,
  output logic [AW-1:0]                    ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0]       ram_wdata,
  output logic [AW-1:0]                    ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]       ram_rdata
);
  import tcw_pkg::*;

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);

  state_t state, state_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [AW-1:0] scan, scan_next;
  logic [COLOR_W-1:0] fg, bg;
  cmd_word_t cmd_q;
  logic in_range_q;

  logic accept;
  logic [AW-1:0] read_idx;
  logic [AW-1:0] cursor_idx;
  logic is_char;
  logic wrap;
  logic scan_last;
  logic [CELL_W-1:0] blank_cell;

  assign cmd_stall  = (state != S_IDLE) || buf_full;
  assign accept     = cmd_valid && !cmd_stall;
  assign read_idx   = AW'(int'(cmd.read_row) * COLUMNS + int'(cmd.read_col));
  assign cursor_idx = AW'(int'(cur_row) * COLUMNS + int'(cur_col));
  assign is_char    = (cmd_q.mode == MODE_PUT) && (cmd_q.char_code != NEWLINE_CHAR);
  // A newline, or a character landing in the last column, ends the line.
  assign wrap       = (cmd_q.mode == MODE_PUT) &&
                      ((cmd_q.char_code == NEWLINE_CHAR) || (cur_col == LAST_COL));
  assign scan_last  = (scan == LAST_CELL);
  assign blank_cell = {bg, fg, BLANK_CHAR};

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (scan_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (wrap && (cur_row == LAST_ROW)) begin
          state_next = S_SCROLL;
        end else if (cmd_q.mode == MODE_CLEAR) begin
          state_next = S_FILL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCROLL, S_FILL: begin
        if (scan_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = scan;
    ram_wdata    = blank_cell;
    ram_raddr    = read_idx;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    scan_next    = scan;
    res_valid    = 1'b0;
    res.cell_value = '0;
    res.scrolled   = 1'b0;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        scan_next = scan + 1'b1;
      end
      S_IDLE: begin
        ram_raddr = read_idx;
      end
      S_EXEC: begin
        unique case (cmd_q.mode)
          MODE_PUT: begin
            if (is_char) begin
              ram_we    = 1'b1;
              ram_waddr = cursor_idx;
              ram_wdata = {bg, fg, cmd_q.char_code};
            end
            if (wrap) begin
              cur_col_next = '0;
              if (cur_row == LAST_ROW) begin
                // Prime the copy: the first source is the start of row one.
                ram_raddr = AW'(COLUMNS);
                scan_next = '0;
              end else begin
                cur_row_next = cur_row + 1'b1;
                res_valid    = 1'b1;
              end
            end else begin
              cur_col_next = cur_col + 1'b1;
              res_valid    = 1'b1;
            end
          end
          MODE_CLEAR: begin
            cur_row_next = '0;
            cur_col_next = '0;
            scan_next    = '0;
          end
          MODE_READ: begin
            res_valid      = 1'b1;
            res.cell_value = in_range_q ? ram_rdata : '0;
          end
          default: begin
            res_valid = 1'b1;
          end
        endcase
      end
      S_SCROLL: begin
        // The source one row below was read in the previous cycle.
        ram_we    = 1'b1;
        ram_wdata = (scan < COPY_END) ? ram_rdata : blank_cell;
        ram_raddr = scan + AW'(COLUMNS + 1);
        scan_next = scan + 1'b1;
        if (scan_last) begin
          res_valid    = 1'b1;
          res.scrolled = 1'b1;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        scan_next = scan + 1'b1;
        if (scan_last) res_valid = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    res.cursor_row_now = ROW_W'(cur_row_next);
    res.cursor_col_now = COL_W'(cur_col_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      scan    <= '0;
      cur_row <= '0;
      cur_col <= '0;
      fg      <= RESET_FG;
      bg      <= RESET_BG;
    end else begin
      state   <= state_next;
      scan    <= scan_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FG: fg <= cfg_data;
          CFG_BG: bg <= cfg_data;
          default: fg <= fg;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= cmd;
      in_range_q <= (int'(cmd.read_row) < ROWS) && (int'(cmd.read_col) < COLUMNS);
    end
  end

  `TCW_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC)
  `TCW_ASSERT(a_row_in_range, clk, rst, cur_row <= LAST_ROW)
  `TCW_ASSERT(a_sweep_writes, clk, rst, (state != S_SCROLL && state != S_FILL) || ram_we)
  `TCW_ASSERT(a_no_result_idle, clk, rst, !(res_valid && (state == S_IDLE || state == S_INIT)))

endmodule

// File: rtl/core/tcw_outbuf.sv
// Response register with a one-word skid stage behind it.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  tcw_pkg::rsp_word_t res,
  output logic               full,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tcw_pkg::rsp_word_t rsp
);
  import tcw_pkg::*;

  logic      skid_valid;
  rsp_word_t skid;
  logic      take;

  assign take = rsp_valid && !rsp_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      if (!rsp_valid || take) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      rsp_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      if (!rsp_valid || take) begin
        rsp <= res;
      end else begin
        skid <= res;
      end
    end else if (take && skid_valid) begin
      rsp <= skid;
    end
  end

  `TCW_ASSERT(a_res_skid_free, clk, rst, !(res_valid && skid_valid))
  `TCW_ASSERT(a_skid_behind_out, clk, rst, !skid_valid || rsp_valid)
  `TCW_ASSERT_NEXT(a_stall_to_skid, clk, rst, res_valid && rsp_valid && rsp_stall, skid_valid)

endmodule

// File: rtl/core/text_console_writer_core.sv
// Text console writer: put, newline, clear and read on a screen of ROWS x COLUMNS cells.
// A put or read word answers via the execute state and the response register; the next word
// is taken once the last is done and the output buffer has room. Newline on the last row or
// a wrap there scrolls the screen; clear likewise sweeps it, one cell per cycle through the
// single write port of the screen RAM. After rst (synchronous) a clearing pass blanks the
// screen before the first command is taken; configuration writes are accepted meanwhile.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  tcw_pkg::cmd_word_t             cmd,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output tcw_pkg::rsp_word_t             rsp,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic              buf_full;
  logic              res_valid;
  rsp_word_t         res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tcw_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .buf_full (buf_full),
    .res_valid(res_valid),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  tcw_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .full     (buf_full),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

// File: tb/sv/text_console_writer_core_tb.sv
// Self-checking bench for text_console_writer_core: a directed table, then random phases
// under several colour settings, checked against a cycle-free screen and cursor predictor.
// Depends on tcw_pkg and the core RTL only.
module text_console_writer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int CELLS = ROWS * COLS;
  localparam int CMD_W = $bits(cmd_word_t);
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 280;
  localparam int WALK_BUDGET = 30;
  localparam int HOLD_AFTER_WORDS = 700;
  localparam int HOLD_CYCLES = 500;
  localparam longint RUN_LIMIT_NS = 30_000_000;

  typedef enum {ROW_PREDICTED, ROW_TYPED, ROW_COLOR} row_kind_t;
  typedef enum {SEG_TEXT, SEG_NEWLINES, SEG_READS, SEG_NOISE, SEG_CLEAR} seg_kind_t;

  typedef struct {
    row_kind_t              kind;
    cmd_word_t              word;
    rsp_word_t              reply;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [COLOR_W-1:0]     reg_val;
  } bench_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_word_t            cmd = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_word_t            rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FG;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                 rsp_hold = 1'b0;

  // Screen and cursor as the block should hold them.
  logic [CELL_W-1:0]  screen_model [0:CELLS-1];
  int                 cur_row;
  int                 cur_col;
  logic [COLOR_W-1:0] fg_now;
  logic [COLOR_W-1:0] bg_now;

  rsp_word_t  console_replies [$];
  bench_row_t directed_rows [$];

  int errors = 0;
  int words_sent = 0;
  int replies_checked = 0;
  int scrolls_seen = 0;
  int clears_seen = 0;
  int color_writes = 0;
  int burst_left = 0;
  int style_left = 0;
  int stall_style = 0;
  int stall_phase = 0;

  text_console_writer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("text_console_writer_core_tb: errors");
    $finish;
  end

  function automatic logic [CELL_W-1:0] tinted(input logic [CHAR_W-1:0] ch);
    return {bg_now, fg_now, ch};
  endfunction

  // Ends the current line; on the last row the screen moves up and the bottom row blanks.
  function automatic bit finish_line();
    int i;
    cur_col = 0;
    if (cur_row < ROWS - 1) begin
      cur_row++;
      return 1'b0;
    end
    for (i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
    for (i = CELLS - COLS; i < CELLS; i++) screen_model[i] = tinted(BLANK_CHAR);
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic rsp_word_t apply_console_cmd(input cmd_word_t c);
    rsp_word_t r;
    int i;
    r = '0;
    case (c.mode)
      MODE_PUT: begin
        if (c.char_code == NEWLINE_CHAR) begin
          r.scrolled = finish_line();
        end else begin
          screen_model[cur_row * COLS + cur_col] = tinted(c.char_code);
          cur_col++;
          if (cur_col >= COLS) r.scrolled = finish_line();
        end
      end
      MODE_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_model[i] = tinted(BLANK_CHAR);
        cur_row = 0;
        cur_col = 0;
        clears_seen++;
      end
      MODE_READ: begin
        if (c.read_row < ROWS && c.read_col < COLS)
          r.cell_value = screen_model[c.read_row * COLS + c.read_col];
      end
      default: ;
    endcase
    if (r.scrolled) scrolls_seen++;
    r.cursor_row_now = ROW_W'(cur_row);
    r.cursor_col_now = COL_W'(cur_col);
    return r;
  endfunction

  // True when the word would make the block walk the whole screen.
  function automatic bit walks_screen(input cmd_word_t c);
    if (c.mode == MODE_CLEAR) return 1'b1;
    if (c.mode != MODE_PUT || cur_row != ROWS - 1) return 1'b0;
    return c.char_code == NEWLINE_CHAR || cur_col == COLS - 1;
  endfunction

  function automatic cmd_word_t pick_word(input seg_kind_t kind);
    cmd_word_t c;
    logic [CMD_W-1:0] raw;
    int roll;
    raw = CMD_W'($urandom);
    c = raw;
    roll = $urandom_range(99);
    case (kind)
      SEG_TEXT: begin
        if (roll < 85) begin
          c.mode = MODE_PUT;
        end else if (roll < 93) begin
          c.mode = MODE_PUT;
          c.char_code = NEWLINE_CHAR;
        end else begin
          c.mode = MODE_READ;
          c.read_row = ROW_W'(cur_row);
          c.read_col = COL_W'($urandom_range(COLS - 1));
        end
      end
      SEG_NEWLINES: begin
        c.mode = MODE_PUT;
        c.char_code = NEWLINE_CHAR;
      end
      SEG_READS: begin
        c.mode = MODE_READ;
        if (roll < 85) begin
          c.read_row = ROW_W'($urandom_range(ROWS - 1));
          c.read_col = COL_W'($urandom_range(COLS - 1));
        end
      end
      SEG_CLEAR: c.mode = MODE_CLEAR;
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_word(input cmd_word_t c, input rsp_word_t typed_reply, input bit use_typed);
    rsp_word_t r;
    int gap;
    r = apply_console_cmd(c);
    console_replies.push_back(use_typed ? typed_reply : r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    words_sent++;
  endtask

  // Colour registers change only with the block idle and every reply in.
  task automatic write_color(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    cmd_valid <= 1'b0;
    burst_left = 0;
    while (console_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FG) fg_now = val;
    else bg_now = val;
    color_writes++;
  endtask

  task automatic table_cmd(input row_kind_t kind, input logic [MODE_W-1:0] mode,
                           input logic [CHAR_W-1:0] ch, input int rr, input int rc,
                           input logic [CELL_W-1:0] cell_val, input int er, input int ec,
                           input bit sc);
    bench_row_t row;
    row.kind = kind;
    row.word.mode = mode;
    row.word.char_code = ch;
    row.word.read_row = ROW_W'(rr);
    row.word.read_col = COL_W'(rc);
    row.reply.cell_value = cell_val;
    row.reply.cursor_row_now = ROW_W'(er);
    row.reply.cursor_col_now = COL_W'(ec);
    row.reply.scrolled = sc;
    row.reg_idx = CFG_FG;
    row.reg_val = '0;
    directed_rows.push_back(row);
  endtask

  task automatic table_color(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    bench_row_t row;
    row.kind = ROW_COLOR;
    row.word = '0;
    row.reply = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_rows.push_back(row);
  endtask

  task automatic run_phase(input int quota);
    int counted;
    int seg_left;
    int walks_left;
    int roll;
    seg_kind_t kind;
    cmd_word_t c;
    counted = 0;
    walks_left = WALK_BUDGET;
    while (counted < quota) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        kind = SEG_TEXT;
        seg_left = $urandom_range(10, 90);
      end else if (roll < 58) begin
        kind = SEG_NEWLINES;
        seg_left = $urandom_range(3, 26);
      end else if (roll < 84) begin
        kind = SEG_READS;
        seg_left = $urandom_range(4, 20);
      end else if (roll < 95) begin
        kind = SEG_NOISE;
        seg_left = $urandom_range(2, 8);
      end else begin
        kind = SEG_CLEAR;
        seg_left = 1;
      end
      while (seg_left > 0 && counted < quota) begin
        c = pick_word(kind);
        // Screen walks sweep every cell; past the budget they become reads.
        if (walks_screen(c)) begin
          if (walks_left == 0) begin
            c.mode = MODE_READ;
            c.read_row = ROW_W'(cur_row);
          end else begin
            walks_left--;
          end
        end
        send_word(c, '0, 1'b0);
        if (c.mode != MODE_UNUSED) counted++;
        seg_left--;
      end
    end
  endtask

  task automatic check_reply(input rsp_word_t want, input rsp_word_t got);
    if (got.cell_value !== want.cell_value) begin
      $error("cell_value expected %h got %h", want.cell_value, got.cell_value);
      errors++;
    end
    if (got.cursor_row_now !== want.cursor_row_now) begin
      $error("cursor_row_now expected %0d got %0d", want.cursor_row_now, got.cursor_row_now);
      errors++;
    end
    if (got.cursor_col_now !== want.cursor_col_now) begin
      $error("cursor_col_now expected %0d got %0d", want.cursor_col_now, got.cursor_col_now);
      errors++;
    end
    if (got.scrolled !== want.scrolled) begin
      $error("scrolled expected %0d got %0d", want.scrolled, got.scrolled);
      errors++;
    end
  endtask

  // Reply side: check each accepted word, then choose the stall for the next cycle.
  always @(posedge clk) begin
    rsp_word_t want;
    logic stall_next;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (console_replies.size() == 0) begin
        $error("reply word with none expected: %h", rsp);
        errors++;
      end else begin
        want = console_replies.pop_front();
        check_reply(want, rsp);
        replies_checked++;
      end
    end
    if (style_left == 0) begin
      style_left = $urandom_range(16, 200);
      stall_style = $urandom_range(3);
    end
    style_left--;
    stall_phase++;
    case (stall_style)
      0: stall_next = 1'b0;
      1: stall_next = ($urandom_range(99) < 30);
      2: stall_next = ($urandom_range(99) < 80);
      default: stall_next = stall_phase[2];
    endcase
    rsp_stall <= rsp_hold | stall_next;
  end

  // One long hold-off on the reply side, so the block fills and stalls its input.
  initial begin
    wait (words_sent >= HOLD_AFTER_WORDS);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  initial begin
    int i;
    int p;
    logic [COLOR_W-1:0] fg_pick;
    logic [COLOR_W-1:0] bg_pick;
    fg_now = RESET_FG;
    bg_now = RESET_BG;
    cur_row = 0;
    cur_col = 0;
    for (i = 0; i < CELLS; i++) screen_model[i] = RESET_CELL;

    // Reads at the corners and out of range, the unused mode, puts of extreme bytes,
    // a newline, colour changes and a clear.
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, 0, 0, RESET_CELL, 0, 0, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'hFF, ROWS - 1, COLS - 1, RESET_CELL, 0, 0, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, ROWS, 0, '0, 0, 0, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, 0, COLS, '0, 0, 0, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, 31, 127, '0, 0, 0, 0);
    table_cmd(ROW_TYPED, MODE_UNUSED, 8'hFF, 31, 127, '0, 0, 0, 0);
    table_cmd(ROW_TYPED, MODE_PUT, 8'h41, 0, 0, '0, 0, 1, 0);
    table_cmd(ROW_TYPED, MODE_PUT, 8'hFF, 0, 0, '0, 0, 2, 0);
    table_cmd(ROW_TYPED, MODE_PUT, 8'h00, 0, 0, '0, 0, 3, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, 0, 0, 16'h0741, 0, 3, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, 0, 1, 16'h07FF, 0, 3, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, 0, 2, 16'h0700, 0, 3, 0);
    table_cmd(ROW_TYPED, MODE_PUT, NEWLINE_CHAR, 0, 0, '0, 1, 0, 0);
    table_color(CFG_FG, 4'hF);
    table_color(CFG_BG, 4'hF);
    table_cmd(ROW_PREDICTED, MODE_PUT, 8'h0B, 0, 0, '0, 0, 0, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, 1, 0, 16'hFF0B, 1, 1, 0);
    table_color(CFG_FG, 4'h0);
    table_cmd(ROW_TYPED, MODE_CLEAR, 8'h55, 3, 3, '0, 0, 0, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, 0, 0, 16'hF020, 0, 0, 0);
    table_cmd(ROW_TYPED, MODE_READ, 8'h00, ROWS - 1, COLS - 1, 16'hF020, 0, 0, 0);
    table_color(CFG_FG, RESET_FG);
    table_color(CFG_BG, RESET_BG);
    table_cmd(ROW_PREDICTED, MODE_PUT, 8'h7F, 0, 0, '0, 0, 0, 0);
    table_cmd(ROW_PREDICTED, MODE_PUT, 8'h80, 0, 0, '0, 0, 0, 0);
    table_cmd(ROW_PREDICTED, MODE_PUT, NEWLINE_CHAR, 0, 0, '0, 0, 0, 0);
    table_cmd(ROW_PREDICTED, MODE_READ, 8'h00, 0, 1, '0, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_COLOR)
        write_color(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_word(directed_rows[i].word, directed_rows[i].reply,
                  directed_rows[i].kind == ROW_TYPED);
    end

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin fg_pick = 4'h0; bg_pick = 4'hF; end
        1: begin fg_pick = 4'hF; bg_pick = 4'h0; end
        2: begin fg_pick = 4'hF; bg_pick = 4'hF; end
        3: begin fg_pick = 4'h0; bg_pick = 4'h0; end
        default: begin
          fg_pick = COLOR_W'($urandom);
          bg_pick = COLOR_W'($urandom);
        end
      endcase
      write_color(CFG_FG, fg_pick);
      write_color(CFG_BG, bg_pick);
      run_phase(PHASE_WORDS);
    end

    cmd_valid <= 1'b0;
    while (console_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command words and checked %0d reply words.", words_sent,
             replies_checked);
    $display("Covered %0d scrolls, %0d clears and %0d colour register writes.",
             scrolls_seen, clears_seen, color_writes);
    if (errors == 0) begin
      $display("text_console_writer_core_tb: clean");
    end else begin
      $display("text_console_writer_core_tb: errors");
    end
    $finish;
  end

endmodule
